// ----- rtl/msp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  localparam int COUNTER_RANGE_DEF = 65536;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int ALPHA_W   = 17;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SAT_IN_W  = 66;
  localparam int DIV_W     = 31;
  localparam int QUO_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_ALPHA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_NEGATE = 3'd6;

  localparam logic [CFG_W-1:0]   PROP_GAIN_RST  = 31'd65536;
  localparam logic [CFG_W-1:0]   INTEG_GAIN_RST = 31'd0;
  localparam logic [CFG_W-1:0]   VOLT_LIMIT_RST = 31'd786432;
  localparam logic [CFG_W-1:0]   SPEED_SCALE_RST = 31'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 17'h10000;

  localparam logic [1:0] DIR_COAST = 2'd0;
  localparam logic [1:0] DIR_CW    = 2'd1;
  localparam logic [1:0] DIR_CCW   = 2'd2;

  localparam logic [QUO_W-1:0] DUTY_FULL = 16'hFFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPD_MUL,
    S_TGT_MUL,
    S_SPF_MUL,
    S_SPF_UPD,
    S_P_MUL,
    S_I_MUL,
    S_I_UPD,
    S_CLAMP,
    S_DUTY,
    S_DIV,
    S_DONE
  } msp_state_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  localparam logic signed [SAT_IN_W-1:0] SAT_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [SAT_IN_W-1:0] SAT_MIN = -66'sh0_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = -32'sh8000_0000;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/msp_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msp_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [msp_pkg::MUL_A_W-1:0]  a_i,
  input  wire logic signed [msp_pkg::MUL_B_W-1:0]  b_i,
  output logic signed      [msp_pkg::PROD_W-1:0]   p_o
);

  logic signed [msp_pkg::PROD_W-1:0] p_q;
  logic signed [msp_pkg::PROD_W-1:0] p_d;

  assign p_d = msp_pkg::PROD_W'(a_i) * msp_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- rtl/msp_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msp_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire msp_pkg::div_req_t req_i,
  output msp_pkg::div_rsp_t      rsp_o
);

  localparam int W = msp_pkg::DIV_W;
  localparam int Q = msp_pkg::QUO_W;
  localparam int CW = $clog2(Q);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  den_q, den_d;
  logic [Q-1:0]  quo_q, quo_d;
  logic [W:0]    shifted;
  logic          ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(Q - 1);
      rem_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? W'(shifted - {1'b0, den_q}) : shifted[W-1:0];
      quo_d = {quo_q[Q-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// ----- rtl/motor_speed_pi_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                              role
// in        in_valid_i in_ready_o encoder_count_i target_speed_i  tick request
//           supply_volts_i
// out       out_valid_o out_ready_i direction_o duty_o           tick result
//           drive_volts_o measured_speed_o
// cfg       cfg_we_i cfg_idx_i cfg_wdata_i                       register write
//
// a request steps through the sequencer states, and the 16-step restoring divider
// when the duty needs it; the one shared multiplier is used five times per request
// a new request is taken in the cycle after the result moves to the output register
// the output register holds a result while out_ready_i is low; requests wait behind it
// reset clears the filters, the integrator and the last count, and restores the
// register defaults

module motor_speed_pi_controller #(
  parameter int COUNTER_RANGE = msp_pkg::COUNTER_RANGE_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [15:0]                       encoder_count_i,
  input  wire logic signed [31:0]                target_speed_i,
  input  wire logic [30:0]                       supply_volts_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             direction_o,
  output logic [15:0]                            duty_o,
  output logic signed [31:0]                     drive_volts_o,
  output logic signed [31:0]                     measured_speed_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [msp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [msp_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int CNT_W = $clog2(COUNTER_RANGE);
  localparam logic [CNT_W-1:0] HALF = CNT_W'(COUNTER_RANGE / 2);
  localparam int AW = msp_pkg::MUL_A_W;
  localparam int BW = msp_pkg::MUL_B_W;
  localparam int PW = msp_pkg::PROD_W;
  localparam int SW = msp_pkg::SAT_IN_W;

  msp_pkg::msp_state_e state_q, state_d;

  logic [msp_pkg::CFG_W-1:0]   prop_q, igain_q, vlim_q, scale_q;
  logic [msp_pkg::ALPHA_W-1:0] talpha_q, salpha_q, alpha_w;
  logic                        neg_q;

  logic [CNT_W-1:0]    prev_q;
  logic signed [31:0]  tf_q, sf_q, integ_q;
  logic signed [31:0]  tgt_q, speed_q, p_q, v_q;
  logic [30:0]         sup_q;
  logic signed [CNT_W:0] diff_q, diff_w;
  logic [15:0]         duty_res_q;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          dir_q;
  logic [15:0]         duty_q;
  logic signed [31:0]  drive_q, meas_q;

  logic [CNT_W-1:0]    count, d_raw, d_neg;
  logic signed [AW-1:0] mul_a, err;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-17:0] prod_sh;
  logic signed [31:0]  tf_upd, sf_upd, speed_w, p_w, istep, integ_upd;
  logic signed [32:0]  vsum, lim33;
  logic                over, under;
  logic signed [31:0]  hi_int, lo_int, v_w;
  logic [30:0]         mag;
  logic                div_needed;
  logic                accept, out_load;
  logic [1:0]          dir_w;

  msp_pkg::div_req_t div_req;
  msp_pkg::div_rsp_t div_rsp;

  msp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  msp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // count wrap to signed difference
  assign count  = encoder_count_i[CNT_W-1:0];
  assign d_raw  = count - prev_q;
  assign d_neg  = neg_q ? CNT_W'(CNT_W'(0) - d_raw) : d_raw;
  assign diff_w = (d_neg > HALF) ? $signed({1'b1, d_neg}) : $signed({1'b0, d_neg});

  assign alpha_w = (cfg_wdata_i[msp_pkg::ALPHA_W-1:0] > msp_pkg::ALPHA_ONE) ?
                   msp_pkg::ALPHA_ONE : cfg_wdata_i[msp_pkg::ALPHA_W-1:0];

  assign err     = AW'(tf_q) - AW'(sf_q);
  assign prod_sh = $signed(prod[PW-1:16]);
  assign speed_w = msp_pkg::sat32(SW'(prod));
  assign tf_upd  = msp_pkg::sat32(SW'(tf_q) + SW'(prod_sh));
  assign sf_upd  = msp_pkg::sat32(SW'(sf_q) + SW'(prod_sh));
  assign p_w     = msp_pkg::sat32(SW'(prod_sh));
  assign istep   = msp_pkg::sat32(SW'(prod_sh));
  assign integ_upd = msp_pkg::sat32(SW'(integ_q) + SW'(istep));

  // clamp with back-calculated integrator
  assign vsum   = 33'(p_q) + 33'(integ_q);
  assign lim33  = $signed({2'b00, vlim_q});
  assign over   = vsum > lim33;
  assign under  = vsum < -lim33;
  assign hi_int = msp_pkg::sat32(SW'(lim33) - SW'(p_q));
  assign lo_int = msp_pkg::sat32(-SW'(lim33) - SW'(p_q));
  assign v_w    = over ? 32'(lim33) : (under ? 32'(-lim33) : 32'(vsum));

  assign mag        = v_q[31] ? 31'(-v_q) : v_q[30:0];
  assign div_needed = (sup_q != '0) && (mag < sup_q);

  always_comb begin
    if (v_q == '0) begin
      dir_w = msp_pkg::DIR_COAST;
    end else if (v_q[31]) begin
      dir_w = msp_pkg::DIR_CCW;
    end else begin
      dir_w = msp_pkg::DIR_CW;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msp_pkg::S_IDLE:    if (in_valid_i) state_d = msp_pkg::S_SPD_MUL;
      msp_pkg::S_SPD_MUL: state_d = msp_pkg::S_TGT_MUL;
      msp_pkg::S_TGT_MUL: state_d = msp_pkg::S_SPF_MUL;
      msp_pkg::S_SPF_MUL: state_d = msp_pkg::S_SPF_UPD;
      msp_pkg::S_SPF_UPD: state_d = msp_pkg::S_P_MUL;
      msp_pkg::S_P_MUL:   state_d = msp_pkg::S_I_MUL;
      msp_pkg::S_I_MUL:   state_d = msp_pkg::S_I_UPD;
      msp_pkg::S_I_UPD:   state_d = msp_pkg::S_CLAMP;
      msp_pkg::S_CLAMP:   state_d = msp_pkg::S_DUTY;
      msp_pkg::S_DUTY:    state_d = div_needed ? msp_pkg::S_DIV : msp_pkg::S_DONE;
      msp_pkg::S_DIV:     if (div_rsp.done) state_d = msp_pkg::S_DONE;
      msp_pkg::S_DONE:    if (!out_valid_q || out_ready_i) state_d = msp_pkg::S_IDLE;
      default:            state_d = msp_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o    = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = mag;
    div_req.den   = sup_q;
    out_load      = 1'b0;
    unique case (state_q)
      msp_pkg::S_IDLE: in_ready_o = 1'b1;
      msp_pkg::S_SPD_MUL: begin
        mul_a = AW'(diff_q);
        mul_b = $signed({1'b0, scale_q});
      end
      msp_pkg::S_TGT_MUL: begin
        mul_a = AW'(tgt_q) - AW'(tf_q);
        mul_b = $signed({15'd0, talpha_q});
      end
      msp_pkg::S_SPF_MUL: begin
        mul_a = AW'(speed_q) - AW'(sf_q);
        mul_b = $signed({15'd0, salpha_q});
      end
      msp_pkg::S_P_MUL: begin
        mul_a = err;
        mul_b = $signed({1'b0, prop_q});
      end
      msp_pkg::S_I_MUL: begin
        mul_a = err;
        mul_b = $signed({1'b0, igain_q});
      end
      msp_pkg::S_DUTY: div_req.start = div_needed;
      msp_pkg::S_DONE: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      tf_q        <= '0;
      sf_q        <= '0;
      integ_q     <= '0;
      prop_q      <= msp_pkg::PROP_GAIN_RST;
      igain_q     <= msp_pkg::INTEG_GAIN_RST;
      vlim_q      <= msp_pkg::VOLT_LIMIT_RST;
      talpha_q    <= msp_pkg::ALPHA_ONE;
      salpha_q    <= msp_pkg::ALPHA_ONE;
      scale_q     <= msp_pkg::SPEED_SCALE_RST;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) prev_q <= count;
      if (state_q == msp_pkg::S_SPF_MUL) tf_q <= tf_upd;
      if (state_q == msp_pkg::S_SPF_UPD) sf_q <= sf_upd;
      if (state_q == msp_pkg::S_I_UPD) integ_q <= integ_upd;
      if (state_q == msp_pkg::S_CLAMP) begin
        if (over) begin
          integ_q <= hi_int;
        end else if (under) begin
          integ_q <= lo_int;
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          msp_pkg::CFG_PROP_GAIN:    prop_q   <= cfg_wdata_i;
          msp_pkg::CFG_INTEG_GAIN:   igain_q  <= cfg_wdata_i;
          msp_pkg::CFG_VOLT_LIMIT:   vlim_q   <= cfg_wdata_i;
          msp_pkg::CFG_TARGET_ALPHA: talpha_q <= alpha_w;
          msp_pkg::CFG_SPEED_ALPHA:  salpha_q <= alpha_w;
          msp_pkg::CFG_SPEED_SCALE:  scale_q  <= cfg_wdata_i;
          msp_pkg::CFG_COUNT_NEGATE: neg_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q <= diff_w;
      tgt_q  <= target_speed_i;
      sup_q  <= supply_volts_i;
    end
    if (state_q == msp_pkg::S_TGT_MUL) speed_q <= speed_w;
    if (state_q == msp_pkg::S_I_MUL) p_q <= p_w;
    if (state_q == msp_pkg::S_CLAMP) v_q <= v_w;
    if (state_q == msp_pkg::S_DUTY) begin
      duty_res_q <= (sup_q == '0) ? 16'd0 : msp_pkg::DUTY_FULL;
    end
    if (state_q == msp_pkg::S_DIV && div_rsp.done) duty_res_q <= div_rsp.quo;
    if (out_load) begin
      dir_q   <= dir_w;
      duty_q  <= duty_res_q;
      drive_q <= v_q;
      meas_q  <= sf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign direction_o      = dir_q;
  assign duty_o           = duty_q;
  assign drive_volts_o    = drive_q;
  assign measured_speed_o = meas_q;

endmodule

`default_nettype wire

// ----- rtl/msp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  direction_o,
  input wire logic [15:0] duty_o,
  input wire logic [31:0] drive_volts_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(drive_volts_o) && $stable(duty_o) && $stable(direction_o))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after a request");

  // direction follows drive sign
  a_dir_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((direction_o == msp_pkg::DIR_CCW) == drive_volts_o[31]) &&
      ((direction_o == msp_pkg::DIR_COAST) == (drive_volts_o == 32'd0)))
    else $error("direction does not match drive");

  // zero drive gives zero duty
  a_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (drive_volts_o == 32'd0) |-> duty_o == 16'd0)
    else $error("duty without drive");

endmodule

bind motor_speed_pi_controller msp_checker u_msp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .direction_o   (direction_o),
  .duty_o        (duty_o),
  .drive_volts_o (drive_volts_o)
);

`default_nettype wire

// ----- verif/motor_speed_pi_controller_checker.sv -----
`timescale 1ns / 1ps

module motor_speed_pi_controller_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [15:0]                     encoder_count_i,
  input  logic signed [31:0]              target_speed_i,
  input  logic [30:0]                     supply_volts_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [1:0]                      direction_i,
  input  logic [15:0]                     duty_i,
  input  logic signed [31:0]              drive_volts_i,
  input  logic signed [31:0]              measured_speed_i,
  input  logic                            cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [msp_pkg::CFG_W-1:0]       cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int     HALF_RANGE = msp_pkg::COUNTER_RANGE_DEF / 2;
  localparam longint I32_MAX    = 64'sd2147483647;
  localparam longint I32_MIN    = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]  dir;
    logic [15:0] duty;
    logic [31:0] volts;
    logic [31:0] speed;
  } tick_result_t;

  tick_result_t                result_q[$];
  tick_result_t                want;
  logic [msp_pkg::CFG_W-1:0]   prop_gain, integ_gain, volt_limit, speed_scale;
  logic [msp_pkg::ALPHA_W-1:0] target_alpha, speed_alpha;
  logic                        count_negate;
  logic [15:0]                 prev_cnt;
  longint                      target_lp, speed_lp, integ_acc;
  int                          fails;

  function automatic longint clip32(input longint x);
    if (x > I32_MAX) return I32_MAX;
    if (x < I32_MIN) return I32_MIN;
    return x;
  endfunction

  function automatic longint lowpass(input longint y, input longint x, input longint a);
    return clip32(y + ((a * (x - y)) >>> 16));
  endfunction

  function automatic logic [msp_pkg::ALPHA_W-1:0] alpha_held(
      input logic [msp_pkg::CFG_W-1:0] w);
    return (w[msp_pkg::ALPHA_W-1:0] > msp_pkg::ALPHA_ONE) ?
           msp_pkg::ALPHA_ONE : w[msp_pkg::ALPHA_W-1:0];
  endfunction

  function automatic tick_result_t run_tick(input logic [15:0] cnt,
                                            input logic signed [31:0] tgt,
                                            input logic [30:0] supply);
    tick_result_t        r;
    logic [15:0]         d;
    longint              diff, spd, err, p, v, lim, mag;
    longint unsigned     num, den;
    d = cnt - prev_cnt;
    if (count_negate) begin
      d = 16'd0 - d;
    end
    diff = (d > HALF_RANGE) ? longint'(d) - 2 * HALF_RANGE : longint'(d);
    prev_cnt = cnt;

    spd = clip32(diff * longint'(speed_scale));
    target_lp = lowpass(target_lp, longint'(tgt), longint'(target_alpha));
    speed_lp = lowpass(speed_lp, spd, longint'(speed_alpha));

    err = target_lp - speed_lp;
    p = clip32((err * longint'(prop_gain)) >>> 16);
    integ_acc = clip32(integ_acc + clip32((err * longint'(integ_gain)) >>> 16));
    v = p + integ_acc;
    lim = longint'(volt_limit);
    // back-calculate the integrator when the drive clamps
    if (v > lim) begin
      v = lim;
      integ_acc = clip32(lim - p);
    end
    if (v < -lim) begin
      v = -lim;
      integ_acc = clip32(-lim - p);
    end

    if (v == 0) begin
      r.dir = msp_pkg::DIR_COAST;
    end else if (v > 0) begin
      r.dir = msp_pkg::DIR_CW;
    end else begin
      r.dir = msp_pkg::DIR_CCW;
    end

    mag = (v < 0) ? -v : v;
    if (supply == '0) begin
      r.duty = '0;
    end else begin
      num = mag;
      den = supply;
      num = (num << 16) / den;
      r.duty = (num > msp_pkg::DUTY_FULL) ? msp_pkg::DUTY_FULL : num[15:0];
    end
    r.volts = v[31:0];
    r.speed = speed_lp[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain = msp_pkg::PROP_GAIN_RST;
      integ_gain = msp_pkg::INTEG_GAIN_RST;
      volt_limit = msp_pkg::VOLT_LIMIT_RST;
      speed_scale = msp_pkg::SPEED_SCALE_RST;
      target_alpha = msp_pkg::ALPHA_ONE;
      speed_alpha = msp_pkg::ALPHA_ONE;
      count_negate = 1'b0;
      prev_cnt = '0;
      target_lp = 0;
      speed_lp = 0;
      integ_acc = 0;
      fails = 0;
      result_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          msp_pkg::CFG_PROP_GAIN:    prop_gain = cfg_wdata_i;
          msp_pkg::CFG_INTEG_GAIN:   integ_gain = cfg_wdata_i;
          msp_pkg::CFG_VOLT_LIMIT:   volt_limit = cfg_wdata_i;
          msp_pkg::CFG_TARGET_ALPHA: target_alpha = alpha_held(cfg_wdata_i);
          msp_pkg::CFG_SPEED_ALPHA:  speed_alpha = alpha_held(cfg_wdata_i);
          msp_pkg::CFG_SPEED_SCALE:  speed_scale = cfg_wdata_i;
          msp_pkg::CFG_COUNT_NEGATE: count_negate = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        result_q.push_back(run_tick(encoder_count_i, target_speed_i, supply_volts_i));
      end

      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result with no request pending");
          fails++;
        end else begin
          want = result_q.pop_front();
          if (direction_i !== want.dir) begin
            $error("direction: expected %0d, actual %0d", want.dir, direction_i);
            fails++;
          end
          if (duty_i !== want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, duty_i);
            fails++;
          end
          if (drive_volts_i !== want.volts) begin
            $error("drive_volts: expected %0d, actual %0d",
                   $signed(want.volts), drive_volts_i);
            fails++;
          end
          if (measured_speed_i !== want.speed) begin
            $error("measured_speed: expected %0d, actual %0d",
                   $signed(want.speed), measured_speed_i);
            fails++;
          end
        end
      end

      fail_count_o <= fails;
      pending_o <= result_q.size();
    end
  end

endmodule

// ----- verif/motor_speed_pi_controller_tb.sv -----
`timescale 1ns / 1ps

module motor_speed_pi_controller_tb;
  import msp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam logic [30:0]          SUPPLY_12V = 31'd786432;
  localparam logic [30:0]          WORD_MAX = 31'h7FFF_FFFF;
  localparam int                   PHASES = 6;
  localparam int                   PHASE_TICKS = 75;
  localparam int                   HOLD_CYCLES = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [15:0]           encoder_count_i;
  logic signed [31:0]    target_speed_i;
  logic [30:0]           supply_volts_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            direction_o;
  logic [15:0]           duty_o;
  logic signed [31:0]    drive_volts_o;
  logic signed [31:0]    measured_speed_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_wdata_i;

  int                    fail_count;
  int                    pending;
  int                    holds_asked = 0;
  int                    holds_done = 0;
  bit                    tx_idle_en;
  bit                    rx_idle_en;
  logic [CFG_W-1:0]      cfg_val [8];
  logic [15:0]           enc_pos;

  motor_speed_pi_controller u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .encoder_count_i  (encoder_count_i),
    .target_speed_i   (target_speed_i),
    .supply_volts_i   (supply_volts_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .direction_o      (direction_o),
    .duty_o           (duty_o),
    .drive_volts_o    (drive_volts_o),
    .measured_speed_o (measured_speed_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  motor_speed_pi_controller_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .encoder_count_i  (encoder_count_i),
    .target_speed_i   (target_speed_i),
    .supply_volts_i   (supply_volts_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .direction_i      (direction_o),
    .duty_i           (duty_o),
    .drive_volts_i    (drive_volts_o),
    .measured_speed_i (measured_speed_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("motor_speed_pi_controller: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [CFG_W-1:0] pick_word(input int unsigned span);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WORD_MAX;
      2: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, span));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_W'(ALPHA_ONE);
      2: return CFG_W'(17'h1FFFF);
      3: return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic write_regs();
    for (int i = 0; i <= CFG_SPARE; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_IDX_W'(i);
      cfg_wdata_i <= cfg_val[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_tick(input logic [15:0] cnt, input logic signed [31:0] tgt,
                           input logic [30:0] supply);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    encoder_count_i <= cnt;
    target_speed_i <= tgt;
    supply_volts_i <= supply;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
  endtask

  // result side: random stalls plus the long hold-offs asked for by the stimulus
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (holds_done < holds_asked) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 99) < 30) begin
        out_ready_i <= 1'b0;
        repeat (pick_gap()) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int                 sent, seg, velocity, r;
    logic signed [31:0] goal;
    logic [30:0]        supply;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    encoder_count_i = '0;
    target_speed_i = '0;
    supply_volts_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: coast, clamps both ways, count wrap, half range, zero supply
    cfg_val[CFG_PROP_GAIN] = PROP_GAIN_RST;
    cfg_val[CFG_INTEG_GAIN] = INTEG_GAIN_RST;
    cfg_val[CFG_VOLT_LIMIT] = VOLT_LIMIT_RST;
    cfg_val[CFG_TARGET_ALPHA] = CFG_W'(ALPHA_ONE);
    cfg_val[CFG_SPEED_ALPHA] = CFG_W'(ALPHA_ONE);
    cfg_val[CFG_SPEED_SCALE] = SPEED_SCALE_RST;
    cfg_val[CFG_COUNT_NEGATE] = '0;
    cfg_val[CFG_SPARE] = CFG_W'($urandom);
    write_regs();
    send_tick(16'd0, 32'sd0, SUPPLY_12V);
    send_tick(16'd100, 32'sd0, SUPPLY_12V);
    send_tick(16'd50, 32'sh7FFF_FFFF, SUPPLY_12V);
    send_tick(16'd32818, 32'sh8000_0000, 31'd0);
    send_tick(16'd1051, 32'sd0, WORD_MAX);
    send_tick(16'd65530, 32'sd327680, 31'd1);
    send_tick(16'd5, 32'sd0, SUPPLY_12V);
    send_tick(16'd5, 32'sd131072, SUPPLY_12V);
    settle();

    // saturation everywhere, target alpha written above full scale, negated count
    cfg_val[CFG_PROP_GAIN] = WORD_MAX;
    cfg_val[CFG_INTEG_GAIN] = WORD_MAX;
    cfg_val[CFG_VOLT_LIMIT] = WORD_MAX;
    cfg_val[CFG_TARGET_ALPHA] = CFG_W'(17'h1FFFF);
    cfg_val[CFG_SPEED_ALPHA] = '0;
    cfg_val[CFG_SPEED_SCALE] = WORD_MAX;
    cfg_val[CFG_COUNT_NEGATE] = WORD_MAX;
    cfg_val[CFG_SPARE] = CFG_W'($urandom);
    write_regs();
    send_tick(16'hFFFF, 32'sh7FFF_FFFF, SUPPLY_12V);
    send_tick(16'h0000, 32'sh8000_0000, WORD_MAX);
    send_tick(16'h8000, 32'sh8000_0000, 31'd0);
    send_tick(16'h0001, 32'sh7FFF_FFFF, 31'd1);
    settle();

    // all gains and the clamp at zero
    cfg_val[CFG_PROP_GAIN] = '0;
    cfg_val[CFG_INTEG_GAIN] = '0;
    cfg_val[CFG_VOLT_LIMIT] = '0;
    cfg_val[CFG_TARGET_ALPHA] = '0;
    cfg_val[CFG_SPEED_ALPHA] = WORD_MAX;
    cfg_val[CFG_SPEED_SCALE] = '0;
    cfg_val[CFG_COUNT_NEGATE] = '0;
    cfg_val[CFG_SPARE] = CFG_W'($urandom);
    write_regs();
    send_tick(16'h1234, 32'sh7FFF_FFFF, SUPPLY_12V);
    send_tick(16'hABCD, 32'sh8000_0000, 31'd0);
    settle();

    // integrator winds up against the clamp in both directions
    cfg_val[CFG_PROP_GAIN] = 31'd32768;
    cfg_val[CFG_INTEG_GAIN] = 31'd16384;
    cfg_val[CFG_VOLT_LIMIT] = 31'd262144;
    cfg_val[CFG_TARGET_ALPHA] = 31'd16384;
    cfg_val[CFG_SPEED_ALPHA] = 31'd16384;
    cfg_val[CFG_SPEED_SCALE] = 31'd65536;
    cfg_val[CFG_COUNT_NEGATE] = 31'd1;
    cfg_val[CFG_SPARE] = CFG_W'($urandom);
    write_regs();
    for (int k = 0; k < 10; k++) begin
      send_tick(16'(k * 37), (k % 4 < 2) ? 32'sd196608000 : -32'sd196608000, SUPPLY_12V);
    end
    settle();

    enc_pos = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      cfg_val[CFG_PROP_GAIN] = pick_word(32'd1 << 20);
      cfg_val[CFG_INTEG_GAIN] = pick_word(32'd1 << 16);
      cfg_val[CFG_VOLT_LIMIT] = pick_word(32'd24 << 16);
      cfg_val[CFG_TARGET_ALPHA] = pick_alpha();
      cfg_val[CFG_SPEED_ALPHA] = pick_alpha();
      cfg_val[CFG_SPEED_SCALE] = pick_word(32'd1 << 20);
      cfg_val[CFG_COUNT_NEGATE] = CFG_W'($urandom);
      cfg_val[CFG_SPARE] = CFG_W'($urandom);
      write_regs();
      tx_idle_en = (ph % 3 != 1);
      rx_idle_en = (ph % 3 != 2);
      if (ph % 2 == 0) begin
        holds_asked++;
      end
      sent = 0;
      while (sent < PHASE_TICKS) begin
        // a run of ticks with a steady target and a steady shaft speed
        seg = $urandom_range(1, 20);
        velocity = int'($urandom_range(0, 400)) - 200;
        case ($urandom_range(0, 9))
          0: goal = $urandom;
          1: goal = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          default: goal = int'($urandom_range(0, 393216000)) - 196608000;
        endcase
        for (int k = 0; k < seg && sent < PHASE_TICKS; k++) begin
          r = $urandom_range(0, 19);
          if (r == 0) begin
            enc_pos = 16'($urandom);
          end else if (r == 1) begin
            enc_pos = enc_pos + 16'h8000;
          end else begin
            enc_pos = enc_pos + 16'(velocity + int'($urandom_range(0, 6)) - 3);
          end
          r = $urandom_range(0, 19);
          if (r == 0) begin
            supply = '0;
          end else if (r < 3) begin
            supply = 31'($urandom);
          end else begin
            supply = SUPPLY_12V + 31'($urandom_range(0, 131072)) - 31'd65536;
          end
          send_tick(enc_pos, goal, supply);
          sent++;
        end
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("motor_speed_pi_controller: match");
    end else begin
      $display("motor_speed_pi_controller: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/msp_pkg.sv
rtl/msp_mul.sv
rtl/msp_div.sv
rtl/motor_speed_pi_controller.sv
rtl/msp_checker.sv
verif/motor_speed_pi_controller_checker.sv
verif/motor_speed_pi_controller_tb.sv
